// File: hw/rtl/path_data_tokenizer_core_macros.svh
// assertion macros shared by the path data tokenizer checks
`ifndef PATH_DATA_TOKENIZER_CORE_MACROS_SVH
`define PATH_DATA_TOKENIZER_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define PDT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("path tokenizer check failed");

// next-cycle implication, disabled while reset is asserted
`define PDT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("path tokenizer check failed");

`endif

// File: hw/rtl/pdt_pkg.sv
// shared types, character codes and helpers of the path data tokenizer
`default_nettype none

package pdt_pkg;

	localparam int unsigned CHAR_W  = 8;
	localparam int unsigned PARAM_W = 32;

	typedef enum logic [1:0] {
		TK_COMMAND = 2'd0,
		TK_PARAM   = 2'd1,
		TK_END     = 2'd2,
		TK_ERROR   = 2'd3
	} token_kind_t;

	typedef enum logic [1:0] {
		CMD_C = 2'd0,
		CMD_L = 2'd1,
		CMD_M = 2'd2,
		CMD_Z = 2'd3
	} command_t;

	localparam logic [CHAR_W-1:0] CH_MINUS   = "-";
	localparam logic [CHAR_W-1:0] CH_PLUS    = "+";
	localparam logic [CHAR_W-1:0] CH_DOT     = ".";
	localparam logic [CHAR_W-1:0] CH_COMMA   = ",";
	localparam logic [CHAR_W-1:0] CH_ZERO    = "0";
	localparam logic [CHAR_W-1:0] CH_NINE    = "9";
	localparam logic [CHAR_W-1:0] CH_SPACE   = " ";
	localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR      = 8'h0d;
	localparam logic [CHAR_W-1:0] CH_LOWER_A = "a";
	localparam logic [CHAR_W-1:0] CH_C_UP    = "C";
	localparam logic [CHAR_W-1:0] CH_C_LO    = "c";
	localparam logic [CHAR_W-1:0] CH_L_UP    = "L";
	localparam logic [CHAR_W-1:0] CH_L_LO    = "l";
	localparam logic [CHAR_W-1:0] CH_M_UP    = "M";
	localparam logic [CHAR_W-1:0] CH_M_LO    = "m";
	localparam logic [CHAR_W-1:0] CH_Z_UP    = "Z";
	localparam logic [CHAR_W-1:0] CH_Z_LO    = "z";

	typedef struct packed {
		token_kind_t               kind;
		command_t                  code;
		logic                      rel;
		logic [CHAR_W-1:0]         orig;
		logic signed [PARAM_W-1:0] value;
		logic                      last;
	} token_t;

	function automatic logic is_space(input logic [CHAR_W-1:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic logic is_digit(input logic [CHAR_W-1:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic token_t error_token(input logic [CHAR_W-1:0] c);
		token_t t;
		t      = '0;
		t.kind = TK_ERROR;
		t.orig = c;
		return t;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/pdt_in_if.sv
// character request channel of the path data tokenizer
`default_nettype none

interface pdt_in_if;
	logic                       valid;
	logic                       ready;
	logic [pdt_pkg::CHAR_W-1:0] char_in;
	logic                       end_of_string;

	modport source (output valid, output char_in, output end_of_string, input ready);
	modport sink (input valid, input char_in, input end_of_string, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/pdt_out_if.sv
// token request channel of the path data tokenizer
`default_nettype none

interface pdt_out_if;
	logic                                valid;
	logic                                ready;
	pdt_pkg::token_kind_t                token_kind;
	pdt_pkg::command_t                   command_code;
	logic                                relative_flag;
	logic [pdt_pkg::CHAR_W-1:0]          original_char;
	logic signed [pdt_pkg::PARAM_W-1:0]  param_value;
	logic                                last_of_run;

	modport source (output valid, output token_kind, output command_code,
		output relative_flag, output original_char, output param_value,
		output last_of_run, input ready);
	modport sink (input valid, input token_kind, input command_code,
		input relative_flag, input original_char, input param_value,
		input last_of_run, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/pdt_scan.sv
// scanner state and per-character token decode
`default_nettype none

module pdt_scan #(
	parameter int unsigned VALUE_BITS = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic [pdt_pkg::CHAR_W-1:0] char_in,
	input  logic                       end_of_string,
	output logic [1:0]                 token_count,
	output pdt_pkg::token_t            token0,
	output pdt_pkg::token_t            token1
);
	import pdt_pkg::*;

	// magnitude saturates at 2^(VALUE_BITS-1)-1, which is all ones here
	localparam int unsigned MW = VALUE_BITS - 1;
	localparam logic [MW-1:0] MAG_MAX = '1;

	typedef enum logic [1:0] {
		MODE_START = 2'd0,
		MODE_FIRST = 2'd1,
		MODE_NEXT  = 2'd2
	} scan_mode_t;

	scan_mode_t    mode_q, mode_d;
	logic          innum_q, innum_d;
	logic          neg_q, neg_d;
	logic [MW-1:0] mag_q, mag_d;
	logic          digit_q, digit_d;
	logic          frac_q, frac_d;
	logic          fdt_q, fdt_d;
	logic          rup_q, rup_d;
	logic          comma_q, comma_d;
	logic          hold_q, hold_d;

	logic [3:0]                dval;
	logic [MW+3:0]             acc_ext;
	logic [MW-1:0]             mag_r;
	logic signed [MW:0]        sval;
	logic signed [PARAM_W-1:0] value32;
	logic                      cmd_v;
	command_t                  cmd_code;
	logic                      f_v, g_v, do_begin;
	token_t                    f_tok, g_tok;

	assign dval = char_in[3:0];

	// multiply by ten and add the digit, checked against the ceiling
	assign acc_ext = ({4'b0000, mag_q} << 3) + ({4'b0000, mag_q} << 1)
		+ {{MW{1'b0}}, dval};

	// round half away from zero on the first fraction digit, then apply sign
	assign mag_r = (rup_q && (mag_q != MAG_MAX)) ? mag_q + 1'b1 : mag_q;
	assign sval  = neg_q ? -$signed({1'b0, mag_r}) : $signed({1'b0, mag_r});

	generate
		if (MW + 1 >= PARAM_W) begin : g_trunc
			assign value32 = sval[PARAM_W-1:0];
		end else begin : g_extend
			assign value32 = {{(PARAM_W-MW-1){sval[MW]}}, sval};
		end
	endgenerate

	always_comb begin
		cmd_v    = 1'b1;
		cmd_code = CMD_C;
		case (char_in)
			CH_C_UP, CH_C_LO: cmd_code = CMD_C;
			CH_L_UP, CH_L_LO: cmd_code = CMD_L;
			CH_M_UP, CH_M_LO: cmd_code = CMD_M;
			CH_Z_UP, CH_Z_LO: cmd_code = CMD_Z;
			default:          cmd_v    = 1'b0;
		endcase
	end

	always_comb begin
		mode_d   = mode_q;
		innum_d  = innum_q;
		neg_d    = neg_q;
		mag_d    = mag_q;
		digit_d  = digit_q;
		frac_d   = frac_q;
		fdt_d    = fdt_q;
		rup_d    = rup_q;
		comma_d  = comma_q;
		hold_d   = hold_q;
		f_v      = 1'b0;
		g_v      = 1'b0;
		f_tok    = '0;
		g_tok    = '0;
		do_begin = 1'b0;

		if (step) begin
			if (end_of_string) begin
				if (!hold_q && innum_q) begin
					f_v = 1'b1;
					if (!digit_q) begin
						f_tok = error_token('0);
					end else begin
						f_tok.kind  = TK_PARAM;
						f_tok.value = value32;
					end
				end
				g_v        = 1'b1;
				g_tok.kind = TK_END;
				mode_d     = MODE_START;
				innum_d    = 1'b0;
				neg_d      = 1'b0;
				mag_d      = '0;
				digit_d    = 1'b0;
				frac_d     = 1'b0;
				fdt_d      = 1'b0;
				rup_d      = 1'b0;
				comma_d    = 1'b0;
				hold_d     = 1'b0;
			end else if (!hold_q) begin
				if (innum_q) begin
					if (is_digit(char_in)) begin
						digit_d = 1'b1;
						if (!frac_q) begin
							mag_d = (acc_ext > {4'b0000, MAG_MAX}) ? MAG_MAX : acc_ext[MW-1:0];
						end else if (!fdt_q) begin
							fdt_d = 1'b1;
							rup_d = (dval >= 4'd5);
						end
					end else if ((char_in == CH_DOT) && !frac_q) begin
						frac_d = 1'b1;
					end else begin
						// number ends here
						f_v     = 1'b1;
						innum_d = 1'b0;
						neg_d   = 1'b0;
						mag_d   = '0;
						digit_d = 1'b0;
						frac_d  = 1'b0;
						fdt_d   = 1'b0;
						rup_d   = 1'b0;
						if (!digit_q) begin
							f_tok  = error_token(char_in);
							hold_d = 1'b1;
						end else begin
							f_tok.kind  = TK_PARAM;
							f_tok.value = value32;
							mode_d      = MODE_NEXT;
							comma_d     = 1'b0;
							do_begin    = 1'b1;
						end
					end
				end else begin
					do_begin = 1'b1;
				end
			end
		end

		if (do_begin && !is_space(char_in)) begin
			if (cmd_v) begin
				g_v        = 1'b1;
				g_tok.kind = TK_COMMAND;
				g_tok.code = cmd_code;
				g_tok.rel  = (char_in >= CH_LOWER_A);
				g_tok.orig = char_in;
				mode_d     = MODE_FIRST;
				comma_d    = 1'b0;
			end else if (mode_d == MODE_START) begin
				g_v    = 1'b1;
				g_tok  = error_token(char_in);
				hold_d = 1'b1;
			end else if (char_in == CH_COMMA) begin
				if ((mode_d == MODE_NEXT) && !comma_d) begin
					comma_d = 1'b1;
				end else begin
					g_v    = 1'b1;
					g_tok  = error_token(char_in);
					hold_d = 1'b1;
				end
			end else if (is_digit(char_in) || (char_in == CH_PLUS) || (char_in == CH_MINUS)
				|| (char_in == CH_DOT)) begin
				innum_d = 1'b1;
				neg_d   = (char_in == CH_MINUS);
				frac_d  = (char_in == CH_DOT);
				fdt_d   = 1'b0;
				rup_d   = 1'b0;
				digit_d = is_digit(char_in);
				mag_d   = is_digit(char_in) ? {{(MW-4){1'b0}}, dval} : '0;
			end else begin
				g_v    = 1'b1;
				g_tok  = error_token(char_in);
				hold_d = 1'b1;
			end
		end
	end

	// pack the finishing token first, the new token second
	always_comb begin
		token_count = {1'b0, f_v} + {1'b0, g_v};
		token0      = f_v ? f_tok : g_tok;
		token0.last = !(f_v && g_v);
		token1      = g_tok;
		token1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_START;
			innum_q <= 1'b0;
			neg_q   <= 1'b0;
			mag_q   <= '0;
			digit_q <= 1'b0;
			frac_q  <= 1'b0;
			fdt_q   <= 1'b0;
			rup_q   <= 1'b0;
			comma_q <= 1'b0;
			hold_q  <= 1'b0;
		end else begin
			mode_q  <= mode_d;
			innum_q <= innum_d;
			neg_q   <= neg_d;
			mag_q   <= mag_d;
			digit_q <= digit_d;
			frac_q  <= frac_d;
			fdt_q   <= fdt_d;
			rup_q   <= rup_d;
			comma_q <= comma_d;
			hold_q  <= hold_d;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/pdt_result_fifo.sv
// four-entry token queue, up to two writes and one read per cycle
`default_nettype none

module pdt_result_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [1:0]      push_count,
	input  pdt_pkg::token_t push0,
	input  pdt_pkg::token_t push1,
	output logic            room,
	output logic            head_valid,
	input  logic            head_ready,
	output pdt_pkg::token_t head
);
	import pdt_pkg::*;

	localparam int unsigned DEPTH = 4;
	localparam int unsigned AW    = $clog2(DEPTH);

	token_t        mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;
	logic          pop;

	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_q];
	assign pop        = head_valid && head_ready;
	// room for a full pair of tokens
	assign room       = (cnt_q <= (AW+1)'(DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push_count != 2'd0) begin
			mem_q[wr_q] <= push0;
		end
		if (push_count == 2'd2) begin
			mem_q[AW'(wr_q + 1'b1)] <= push1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= AW'(wr_q + push_count);
			rd_q  <= AW'(rd_q + pop);
			cnt_q <= cnt_q + (AW+1)'(push_count) - (AW+1)'(pop);
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/path_data_tokenizer_core.sv
// top level of the path data tokenizer
//
// char_ch takes one request per cycle while ready is high: a path character,
// or an end-of-string mark with end_of_string high. token_ch returns the
// tokens that each request causes, in order: commands, rounded signed
// parameters, end of input and error, with last_of_run high on the final
// token of a request. A request may cause no token (whitespace, a single
// comma, a digit inside a number, anything but end of string after an
// error) or up to two (a number closed by a command, a bad character or
// end of string). A four-entry token queue sits behind the scanner.
// Throughput: one request per cycle while each causes at most one token;
// a request that causes two drains one token at a time. The input keeps
// flowing while token_ch stalls until the queue cannot take two more tokens,
// then char_ch.ready drops; ready never depends on token_ch.ready directly.
// Reset clears the scanner to expect a leading command and empties the
// queue. End of string always resets the scanner for the next string.
`default_nettype none

module path_data_tokenizer_core #(
	parameter int unsigned VALUE_BITS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	pdt_in_if.sink    char_ch,
	pdt_out_if.source token_ch
);
	import pdt_pkg::*;

	// input register
	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              eos_s1;
	logic              advance_s1;

	// scanner results and queue status
	logic       room;
	logic [1:0] token_count;
	token_t     token0, token1;
	logic       head_valid;
	token_t     head;

	// stage 1 moves into the queue whenever two slots are free
	assign advance_s1    = valid_s1 && room;
	assign char_ch.ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_ch.ready) begin
			valid_s1 <= char_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_ch.valid && char_ch.ready) begin
			char_s1 <= char_ch.char_in;
			eos_s1  <= char_ch.end_of_string;
		end
	end

	pdt_scan #(
		.VALUE_BITS (VALUE_BITS)
	) u_scan (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance_s1),
		.char_in       (char_s1),
		.end_of_string (eos_s1),
		.token_count   (token_count),
		.token0        (token0),
		.token1        (token1)
	);

	pdt_result_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_count (token_count),
		.push0      (token0),
		.push1      (token1),
		.room       (room),
		.head_valid (head_valid),
		.head_ready (token_ch.ready),
		.head       (head)
	);

	// queue head drives the token channel
	assign token_ch.valid         = head_valid;
	assign token_ch.token_kind    = head.kind;
	assign token_ch.command_code  = head.code;
	assign token_ch.relative_flag = head.rel;
	assign token_ch.original_char = head.orig;
	assign token_ch.param_value   = head.value;
	assign token_ch.last_of_run   = head.last;

endmodule

`default_nettype wire

// File: hw/rtl/pdt_checker.sv
// port-level checks of the path data tokenizer and their binding
`default_nettype none
`include "path_data_tokenizer_core_macros.svh"

module pdt_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               tok_valid,
	input logic                               tok_ready,
	input pdt_pkg::token_kind_t               token_kind,
	input pdt_pkg::command_t                  command_code,
	input logic                               relative_flag,
	input logic [pdt_pkg::CHAR_W-1:0]         original_char,
	input logic signed [pdt_pkg::PARAM_W-1:0] param_value,
	input logic                               last_of_run
);
	import pdt_pkg::*;

	logic [$bits(token_t)-1:0] token_bits;

	assign token_bits = {token_kind, command_code, relative_flag, original_char,
		param_value, last_of_run};

	// a stalled token stays offered and unchanged
	`PDT_ASSERT_NEXT(a_token_hold, clk, arst_n, tok_valid && !tok_ready, tok_valid && $stable(token_bits))

	// end of input is always the final token of its request
	`PDT_ASSERT_IMPLY(a_end_is_last, clk, arst_n, tok_valid && (token_kind == TK_END), last_of_run)

	// error tokens carry only the offending character
	`PDT_ASSERT_IMPLY(a_error_clean, clk, arst_n, tok_valid && (token_kind == TK_ERROR), (command_code == CMD_C) && !relative_flag && (param_value == '0))

	// parameter tokens carry only the value
	`PDT_ASSERT_IMPLY(a_param_clean, clk, arst_n, tok_valid && (token_kind == TK_PARAM), (command_code == CMD_C) && !relative_flag && (original_char == '0))

endmodule

bind path_data_tokenizer_core pdt_checker u_pdt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.tok_valid     (token_ch.valid),
	.tok_ready     (token_ch.ready),
	.token_kind    (token_ch.token_kind),
	.command_code  (token_ch.command_code),
	.relative_flag (token_ch.relative_flag),
	.original_char (token_ch.original_char),
	.param_value   (token_ch.param_value),
	.last_of_run   (token_ch.last_of_run)
);

`default_nettype wire
